/* rtl/srgt_pkg.sv */
// Shared constants and types for the survival ratio generation tuner.
// Used by the channel interfaces, the top level and the checker; no dependencies.
package srgt_pkg;

	// Field widths
	localparam int BYTES_W   = 36;
	localparam int AGE_W     = 8;
	localparam int FRAC_W    = 16;
	localparam int RATIO_W   = FRAC_W + 1;
	localparam int TARGET_W  = 16;
	localparam int WIN_W     = 6;
	localparam int TOTAL_W   = 32;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = BYTES_W;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_NURSERY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_NURSERY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_AGE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 3'd5;

	// Register reset values
	localparam logic [BYTES_W-1:0]  RST_MIN_NURSERY = 36'd2097152;
	localparam logic [BYTES_W-1:0]  RST_MAX_NURSERY = 36'd16777216;
	localparam logic [AGE_W-1:0]    RST_MIN_AGE     = 8'd2;
	localparam logic [AGE_W-1:0]    RST_MAX_AGE     = 8'd8;
	localparam logic [TARGET_W-1:0] RST_TARGET      = 16'd9830;
	localparam logic [WIN_W-1:0]    RST_WINDOW      = 6'd8;

	// Unity survival ratio in Q1.16
	localparam logic [RATIO_W-1:0] Q_ONE = 17'h10000;
	localparam logic [AGE_W-1:0]   AGE_TOP = 8'hFF;

	localparam int RING_DEPTH_DEF = 32;

	typedef logic [BYTES_W-1:0] bytes_t;
	typedef logic [AGE_W-1:0]   age_t;
	typedef logic [TOTAL_W-1:0] total_t;

endpackage

/* rtl/srgt_if.sv */
// Valid/ready channel interfaces for the survival ratio generation tuner:
// collection items in, tuning results out, and configuration writes.
// Depends on srgt_pkg for field widths.

interface srgt_in_if;
	logic                 valid;
	logic                 ready;
	srgt_pkg::bytes_t     allocated_bytes;
	srgt_pkg::bytes_t     survived_bytes;

	modport source (output valid, output allocated_bytes, output survived_bytes, input ready);
	modport sink   (input valid, input allocated_bytes, input survived_bytes, output ready);
endinterface

interface srgt_out_if;
	logic                 valid;
	logic                 ready;
	srgt_pkg::bytes_t     nursery_bytes;
	srgt_pkg::age_t       promote_age;
	logic                 nursery_changed;
	logic                 age_changed;
	srgt_pkg::total_t     resize_total;
	srgt_pkg::total_t     age_change_total;

	modport source (output valid, output nursery_bytes, output promote_age,
		output nursery_changed, output age_changed, output resize_total,
		output age_change_total, input ready);
	modport sink   (input valid, input nursery_bytes, input promote_age,
		input nursery_changed, input age_changed, input resize_total,
		input age_change_total, output ready);
endinterface

interface srgt_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [srgt_pkg::CFG_IDX_W-1:0]      index;
	logic [srgt_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/survival_ratio_generation_tuner.sv */
// Survival ratio generation tuner: top level with FSM, bit-serial divider and ratio ring.
// Depends on srgt_pkg and the channel interfaces in srgt_if.sv.
// An accepted item passes through one compare state, 16 divider steps, the ring write and the
// output load before its result is offered; a zero allocation or full survival skips the divider.
// A rebalancing item adds a walk over the filled ratios, the mean divider steps and the decision
// states (decide, clamp, update). One item at a time: the next can be taken in the same cycle as
// the result is offered, and a stalled result holds the block. Reset: asynchronous, active low;
// registers take their documented defaults, ring unset.
module survival_ratio_generation_tuner #(
	parameter int RING_DEPTH = srgt_pkg::RING_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	srgt_in_if.sink    collect,
	srgt_out_if.source result,
	srgt_cfg_if.sink   cfg
);

	localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W  = $clog2(RING_DEPTH + 1);
	localparam int SUM_W  = srgt_pkg::RATIO_W + PTR_W;
	localparam int STEP_W = $clog2(SUM_W + 1);
	localparam int BW     = srgt_pkg::BYTES_W;
	localparam int AW     = srgt_pkg::AGE_W;
	localparam int RW     = srgt_pkg::RATIO_W;
	localparam int TW     = srgt_pkg::TARGET_W;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PREP  = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_WRITE = 4'd3;
	localparam logic [3:0] S_SUM   = 4'd4;
	localparam logic [3:0] S_DEC   = 4'd5;
	localparam logic [3:0] S_CLAMP = 4'd6;
	localparam logic [3:0] S_UPD   = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0] state_q;

	// Configuration registers
	srgt_pkg::bytes_t min_n_q, max_n_q;
	srgt_pkg::age_t   min_a_q, max_a_q;
	logic [TW-1:0]    target_q;
	logic [srgt_pkg::WIN_W-1:0] win_q;

	// Tuning state
	logic [PTR_W-1:0] ptr_q;
	logic [CNT_W-1:0] filled_q;
	srgt_pkg::bytes_t nursery_q;
	srgt_pkg::age_t   age_q;
	srgt_pkg::total_t resize_cnt_q, age_cnt_q;

	// Divider
	logic [BW:0]       rem_q;
	srgt_pkg::bytes_t  dvs_q;
	logic [SUM_W-1:0]  dvd_q, quo_q;
	logic [STEP_W-1:0] step_q;
	logic              mean_mode_q;

	// Ring walk
	logic [RW-1:0]    ring [RING_DEPTH];
	logic [RW-1:0]    rdata_q;
	logic [CNT_W-1:0] issue_q, cnt_q;
	logic             rd_vld_s1;
	logic [SUM_W-1:0] sum_q;

	// Decision and candidates
	logic             grow_n_q, grow_a_q, shrink_q, shrink_ok_q;
	logic [BW:0]      dbl_q;
	srgt_pkg::bytes_t half_q, cand_n_q;
	srgt_pkg::age_t   inc_q, dec_q, cand_a_q;

	// Output register
	logic             out_valid_q, ncg_q, acg_q;
	srgt_pkg::bytes_t out_n_q;
	srgt_pkg::age_t   out_a_q;
	logic             out_ncg_q, out_acg_q;
	srgt_pkg::total_t out_rc_q, out_ac_q;

	logic [CNT_W-1:0] w_eff;
	logic [PTR_W-1:0] wr_ptr;
	logic [CNT_W-1:0] next_ptr, filled_next;
	logic             wrap;
	logic [BW:0]      div_r2;
	logic             div_ge;
	logic             div_last;
	logic             out_free;
	logic [RW-1:0]    avg;

	// A window of zero behaves as one, and anything beyond the ring as the full ring.
	always_comb begin
		if (win_q == '0)
			w_eff = CNT_W'(1);
		else if (int'(win_q) > RING_DEPTH)
			w_eff = CNT_W'(RING_DEPTH);
		else
			w_eff = CNT_W'(win_q);
	end

	// The pointer restarts if the window shrank beneath it.
	assign wr_ptr      = (CNT_W'(ptr_q) >= w_eff) ? '0 : ptr_q;
	assign next_ptr    = CNT_W'(wr_ptr) + CNT_W'(1);
	assign wrap        = next_ptr >= w_eff;
	assign filled_next = (filled_q < w_eff) ? filled_q + CNT_W'(1) : w_eff;

	// One restoring step: bring down the next dividend bit and try the subtraction.
	assign div_r2   = {rem_q[BW-1:0], dvd_q[SUM_W-1]};
	assign div_ge   = div_r2 >= {1'b0, dvs_q};
	assign div_last = step_q == STEP_W'(1);

	assign out_free = !out_valid_q || result.ready;
	assign avg      = quo_q[RW-1:0];

	assign collect.ready = state_q == S_IDLE;
	assign cfg.ready     = 1'b1;

	assign result.valid            = out_valid_q;
	assign result.nursery_bytes    = out_n_q;
	assign result.promote_age      = out_a_q;
	assign result.nursery_changed  = out_ncg_q;
	assign result.age_changed      = out_acg_q;
	assign result.resize_total     = out_rc_q;
	assign result.age_change_total = out_ac_q;

	// Ratio ring
	always_ff @(posedge clk) begin
		if (state_q == S_WRITE)
			ring[wr_ptr] <= quo_q[RW-1:0];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SUM && issue_q < cnt_q)
			rdata_q <= ring[issue_q[PTR_W-1:0]];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			min_n_q      <= srgt_pkg::RST_MIN_NURSERY;
			max_n_q      <= srgt_pkg::RST_MAX_NURSERY;
			min_a_q      <= srgt_pkg::RST_MIN_AGE;
			max_a_q      <= srgt_pkg::RST_MAX_AGE;
			target_q     <= srgt_pkg::RST_TARGET;
			win_q        <= srgt_pkg::RST_WINDOW;
			ptr_q        <= '0;
			filled_q     <= '0;
			nursery_q    <= srgt_pkg::RST_MIN_NURSERY;
			age_q        <= srgt_pkg::RST_MIN_AGE;
			resize_cnt_q <= '0;
			age_cnt_q    <= '0;
			step_q       <= '0;
			mean_mode_q  <= 1'b0;
			issue_q      <= '0;
			cnt_q        <= '0;
			rd_vld_s1    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					srgt_pkg::REG_MIN_NURSERY: begin
						min_n_q   <= cfg.data;
						nursery_q <= cfg.data;
					end
					srgt_pkg::REG_MAX_NURSERY: max_n_q <= cfg.data;
					srgt_pkg::REG_MIN_AGE: begin
						min_a_q <= cfg.data[AW-1:0];
						age_q   <= cfg.data[AW-1:0];
					end
					srgt_pkg::REG_MAX_AGE: max_a_q <= cfg.data[AW-1:0];
					srgt_pkg::REG_TARGET:  target_q <= cfg.data[TW-1:0];
					srgt_pkg::REG_WINDOW:  win_q <= cfg.data[srgt_pkg::WIN_W-1:0];
					default: ;
				endcase
			end

			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (collect.valid)
						state_q <= S_PREP;
				end
				S_PREP: begin
					if (dvs_q == '0 || rem_q >= {1'b0, dvs_q}) begin
						state_q <= S_WRITE;
					end else begin
						step_q      <= STEP_W'(srgt_pkg::FRAC_W);
						mean_mode_q <= 1'b0;
						state_q     <= S_DIV;
					end
				end
				S_DIV: begin
					step_q <= step_q - STEP_W'(1);
					if (div_last)
						state_q <= mean_mode_q ? S_DEC : S_WRITE;
				end
				S_WRITE: begin
					filled_q <= filled_next;
					if (wrap) begin
						ptr_q   <= '0;
						cnt_q   <= filled_next;
						issue_q <= '0;
						state_q <= S_SUM;
					end else begin
						ptr_q   <= next_ptr[PTR_W-1:0];
						state_q <= S_DONE;
					end
				end
				S_SUM: begin
					if (issue_q < cnt_q) begin
						issue_q   <= issue_q + CNT_W'(1);
						rd_vld_s1 <= 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
					end
					if (issue_q == cnt_q && !rd_vld_s1) begin
						step_q      <= STEP_W'(SUM_W);
						mean_mode_q <= 1'b1;
						state_q     <= S_DIV;
					end
				end
				S_DEC: state_q <= S_CLAMP;
				S_CLAMP: state_q <= S_UPD;
				S_UPD: begin
					if (cand_n_q != nursery_q) begin
						nursery_q    <= cand_n_q;
						resize_cnt_q <= resize_cnt_q + srgt_pkg::TOTAL_W'(1);
					end
					if (cand_a_q != age_q) begin
						age_q     <= cand_a_q;
						age_cnt_q <= age_cnt_q + srgt_pkg::TOTAL_W'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (collect.valid) begin
					dvs_q <= collect.allocated_bytes;
					rem_q <= {1'b0, collect.survived_bytes};
				end
			end
			S_PREP: begin
				dvd_q <= '0;
				if (dvs_q == '0)
					quo_q <= '0;
				else if (rem_q >= {1'b0, dvs_q})
					quo_q <= SUM_W'(srgt_pkg::Q_ONE);
				else
					quo_q <= '0;
			end
			S_DIV: begin
				rem_q <= div_ge ? div_r2 - {1'b0, dvs_q} : div_r2;
				quo_q <= {quo_q[SUM_W-2:0], div_ge};
				dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
			end
			S_WRITE: begin
				ncg_q <= 1'b0;
				acg_q <= 1'b0;
				sum_q <= '0;
			end
			S_SUM: begin
				if (rd_vld_s1)
					sum_q <= sum_q + SUM_W'(rdata_q);
				if (issue_q == cnt_q && !rd_vld_s1) begin
					rem_q <= '0;
					dvd_q <= rd_vld_s1 ? sum_q + SUM_W'(rdata_q) : sum_q;
					dvs_q <= BW'(cnt_q);
					quo_q <= '0;
				end
			end
			S_DEC: begin
				grow_n_q    <= avg > {target_q, 1'b0};
				grow_a_q    <= {avg, 1'b0} > ({2'b00, target_q} + {1'b0, target_q, 1'b0});
				shrink_q    <= {avg, 1'b0} < {2'b00, target_q};
				shrink_ok_q <= nursery_q > min_n_q;
				dbl_q       <= {nursery_q, 1'b0};
				half_q      <= {1'b0, nursery_q[BW-1:1]};
				inc_q       <= (age_q == srgt_pkg::AGE_TOP) ? age_q : age_q + AW'(1);
				dec_q       <= (age_q == '0) ? age_q : age_q - AW'(1);
			end
			S_CLAMP: begin
				// Growth may lower a nursery already above its maximum.
				if (grow_n_q)
					cand_n_q <= (dbl_q > {1'b0, max_n_q}) ? max_n_q : dbl_q[BW-1:0];
				else if (shrink_q && shrink_ok_q)
					cand_n_q <= (half_q < min_n_q) ? min_n_q : half_q;
				else
					cand_n_q <= nursery_q;

				if (grow_a_q)
					cand_a_q <= (inc_q > max_a_q) ? max_a_q : inc_q;
				else if (shrink_q)
					cand_a_q <= (dec_q < min_a_q) ? min_a_q : dec_q;
				else
					cand_a_q <= age_q;
			end
			S_UPD: begin
				ncg_q <= cand_n_q != nursery_q;
				acg_q <= cand_a_q != age_q;
			end
			S_DONE: begin
				if (out_free) begin
					out_n_q   <= nursery_q;
					out_a_q   <= age_q;
					out_ncg_q <= ncg_q;
					out_acg_q <= acg_q;
					out_rc_q  <= resize_cnt_q;
					out_ac_q  <= age_cnt_q;
				end
			end
			default: ;
		endcase
	end

endmodule

/* rtl/srgt_checker.sv */
// Port-level checker for the survival ratio generation tuner, with its bind statement.
// Depends on srgt_pkg and on the top level's channel ports.
module srgt_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input srgt_pkg::bytes_t out_nursery,
	input srgt_pkg::age_t   out_age,
	input srgt_pkg::total_t out_resize,
	input srgt_pkg::total_t out_age_total
);

	// A result that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_nursery) && $stable(out_age) &&
			$stable(out_resize) && $stable(out_age_total))
		else $error("stalled result changed");

	// Items are worked on one at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while one is in progress");

	// The block becomes ready again only once the finished item's result is offered.
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> out_valid)
		else $error("ready returned without a result on offer");

	// A fresh result appears only when the block was busy the cycle before.
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while the block was idle");

endmodule

bind survival_ratio_generation_tuner srgt_checker u_srgt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (collect.valid),
	.in_ready      (collect.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.out_nursery   (result.nursery_bytes),
	.out_age       (result.promote_age),
	.out_resize    (result.resize_total),
	.out_age_total (result.age_change_total)
);

/* tb/tb_survival_ratio_generation_tuner.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the survival ratio generation tuner: random collection items and
// register settings go in, and every tuning result is predicted here and checked field by field.
// Depends on srgt_pkg, the channel interfaces in srgt_if.sv and the tuner top level.
module tb_survival_ratio_generation_tuner;

	localparam int WINDOW_MAX = srgt_pkg::RING_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1400;
	localparam int SETTLE_CYCLES = 200;
	localparam srgt_pkg::bytes_t BYTES_MAX = '1;
	localparam logic [srgt_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef struct {
		srgt_pkg::bytes_t allocated;
		srgt_pkg::bytes_t survived;
		bit               drain;
	} collection_t;

	typedef struct {
		srgt_pkg::bytes_t nursery;
		srgt_pkg::age_t   age;
		logic             nursery_changed;
		logic             age_changed;
		srgt_pkg::total_t resizes;
		srgt_pkg::total_t age_changes;
	} tuning_t;

	typedef enum logic [1:0] {STALL_NONE, STALL_SHORT, STALL_LONG} stall_mode_t;

	logic clk;
	logic arst_n;

	srgt_in_if  collect_ch();
	srgt_out_if result_ch();
	srgt_cfg_if cfg_ch();

	survival_ratio_generation_tuner uut (
		.clk    (clk),
		.arst_n (arst_n),
		.collect(collect_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Predicted state of the tuner
	srgt_pkg::bytes_t              min_nursery, max_nursery, nursery_now;
	srgt_pkg::age_t                min_age, max_age, age_now;
	logic [srgt_pkg::TARGET_W-1:0] target;
	logic [srgt_pkg::WIN_W-1:0]    window_reg;
	logic [srgt_pkg::RATIO_W-1:0]  ratios [WINDOW_MAX];
	int unsigned                   write_ptr, filled;
	srgt_pkg::total_t              resize_count, age_count;

	collection_t pending_collections [$];
	tuning_t     expected_tunings [$];
	int unsigned failures = 0;

	function automatic void tune_reset();
		min_nursery = srgt_pkg::RST_MIN_NURSERY;
		max_nursery = srgt_pkg::RST_MAX_NURSERY;
		min_age = srgt_pkg::RST_MIN_AGE;
		max_age = srgt_pkg::RST_MAX_AGE;
		target = srgt_pkg::RST_TARGET;
		window_reg = srgt_pkg::RST_WINDOW;
		foreach (ratios[i])
			ratios[i] = '0;
		write_ptr = 0;
		filled = 0;
		nursery_now = srgt_pkg::RST_MIN_NURSERY;
		age_now = srgt_pkg::RST_MIN_AGE;
		resize_count = '0;
		age_count = '0;
	endfunction

	function automatic void tune_config(logic [srgt_pkg::CFG_IDX_W-1:0] idx,
			logic [srgt_pkg::CFG_DATA_W-1:0] val);
		case (idx)
		srgt_pkg::REG_MIN_NURSERY: begin
			min_nursery = val;
			nursery_now = val;
		end
		srgt_pkg::REG_MAX_NURSERY: max_nursery = val;
		srgt_pkg::REG_MIN_AGE: begin
			min_age = val[srgt_pkg::AGE_W-1:0];
			age_now = val[srgt_pkg::AGE_W-1:0];
		end
		srgt_pkg::REG_MAX_AGE: max_age = val[srgt_pkg::AGE_W-1:0];
		srgt_pkg::REG_TARGET: target = val[srgt_pkg::TARGET_W-1:0];
		srgt_pkg::REG_WINDOW: window_reg = val[srgt_pkg::WIN_W-1:0];
		default: ;
		endcase
	endfunction

	function automatic int unsigned window_eff();
		if (window_reg == 0)
			return 1;
		if (window_reg > WINDOW_MAX)
			return WINDOW_MAX;
		return 32'(window_reg);
	endfunction

	function automatic logic [srgt_pkg::RATIO_W-1:0] survival_ratio(srgt_pkg::bytes_t alloc,
			srgt_pkg::bytes_t surv);
		logic [srgt_pkg::BYTES_W+srgt_pkg::FRAC_W-1:0] scaled;
		logic [srgt_pkg::BYTES_W+srgt_pkg::FRAC_W-1:0] quot;
		scaled = {surv, {srgt_pkg::FRAC_W{1'b0}}};
		if (alloc == 0)
			return '0;
		if (surv >= alloc)
			return srgt_pkg::Q_ONE;
		quot = scaled / alloc;
		return quot[srgt_pkg::RATIO_W-1:0];
	endfunction

	// Records one collection and, when the window wraps, rebalances on the mean ratio.
	function automatic tuning_t tune_step(srgt_pkg::bytes_t alloc, srgt_pkg::bytes_t surv);
		tuning_t res;
		int unsigned w, i;
		longint unsigned sum, avg, t;
		logic [srgt_pkg::BYTES_W:0] grown;
		srgt_pkg::bytes_t shrunk;
		srgt_pkg::age_t next_age;
		w = window_eff();
		res.nursery_changed = 1'b0;
		res.age_changed = 1'b0;
		if (write_ptr >= w)
			write_ptr = 0;
		ratios[write_ptr] = survival_ratio(alloc, surv);
		write_ptr++;
		if (filled < w)
			filled++;
		if (filled > w)
			filled = w;
		if (write_ptr >= w) begin
			write_ptr = 0;
			sum = 0;
			for (i = 0; i < filled; i++)
				sum += 64'(ratios[i]);
			avg = sum / filled;
			t = 64'(target);
			if (avg > 2 * t) begin
				grown = {nursery_now, 1'b0};
				if (grown > {1'b0, max_nursery})
					grown = {1'b0, max_nursery};
				if (grown != {1'b0, nursery_now}) begin
					nursery_now = grown[srgt_pkg::BYTES_W-1:0];
					resize_count++;
					res.nursery_changed = 1'b1;
				end
			end else if (2 * avg < t && nursery_now > min_nursery) begin
				shrunk = nursery_now >> 1;
				if (shrunk < min_nursery)
					shrunk = min_nursery;
				if (shrunk != nursery_now) begin
					nursery_now = shrunk;
					resize_count++;
					res.nursery_changed = 1'b1;
				end
			end
			if (2 * avg > 3 * t) begin
				next_age = (age_now == srgt_pkg::AGE_TOP) ? srgt_pkg::AGE_TOP : age_now + 8'd1;
				if (next_age > max_age)
					next_age = max_age;
				if (next_age != age_now) begin
					age_now = next_age;
					age_count++;
					res.age_changed = 1'b1;
				end
			end else if (2 * avg < t) begin
				next_age = (age_now == 0) ? 8'd0 : age_now - 8'd1;
				if (next_age < min_age)
					next_age = min_age;
				if (next_age != age_now) begin
					age_now = next_age;
					age_count++;
					res.age_changed = 1'b1;
				end
			end
		end
		res.nursery = nursery_now;
		res.age = age_now;
		res.resizes = resize_count;
		res.age_changes = age_count;
		return res;
	endfunction

	function automatic srgt_pkg::bytes_t rand_bytes(int unsigned bits);
		logic [63:0] raw;
		srgt_pkg::bytes_t v;
		raw = {$urandom(), $urandom()};
		v = raw[srgt_pkg::BYTES_W-1:0];
		if (bits < srgt_pkg::BYTES_W)
			v = v & ((srgt_pkg::bytes_t'(1) << bits) - 1);
		return v;
	endfunction

	function automatic srgt_pkg::bytes_t pick_bytes();
		case ($urandom_range(5, 0))
		0: return '0;
		1: return BYTES_MAX;
		2: return rand_bytes(srgt_pkg::BYTES_W);
		default: return rand_bytes($urandom_range(28, 16));
		endcase
	endfunction

	function automatic srgt_pkg::bytes_t pick_age(int unsigned top);
		case ($urandom_range(5, 0))
		0: return '0;
		1: return srgt_pkg::bytes_t'(srgt_pkg::AGE_TOP);
		default: return srgt_pkg::bytes_t'($urandom_range(top, 0));
		endcase
	endfunction

	function automatic srgt_pkg::bytes_t pick_window();
		case ($urandom_range(5, 0))
		0: return '0;
		1: return srgt_pkg::bytes_t'(1);
		2: return srgt_pkg::bytes_t'(WINDOW_MAX);
		3: return srgt_pkg::bytes_t'($urandom_range(63, WINDOW_MAX + 1));
		default: return srgt_pkg::bytes_t'($urandom_range(12, 2));
		endcase
	endfunction

	// Centre of a window's ratios, placed on and around the decision thresholds.
	function automatic int unsigned pick_centre();
		int unsigned t;
		t = 32'(target);
		case ($urandom_range(9, 0))
		0: return 0;
		1: return t / 4;
		2: return t / 2;
		3: return (t + 1) / 2;
		4: return t;
		5: return 3 * t / 2;
		6: return 3 * t / 2 + 1;
		7: return 2 * t;
		8: return 2 * t + 1;
		default: return $urandom_range(32'(srgt_pkg::Q_ONE), 0);
		endcase
	endfunction

	function automatic int unsigned pick_spread();
		case ($urandom_range(3, 0))
		2: return 16;
		3: return 2048;
		default: return 0;
		endcase
	endfunction

	function automatic int unsigned near_ratio(int unsigned centre, int unsigned spread);
		int r;
		r = int'(centre) + int'($urandom_range(2 * spread, 0)) - int'(spread);
		if (r < 0)
			r = 0;
		if (r > int'(srgt_pkg::Q_ONE))
			r = int'(srgt_pkg::Q_ONE);
		return r;
	endfunction

	// Builds a collection whose survival ratio is close to the one asked for; a few items are
	// noise: nothing allocated, survival at or above allocation, or fully random counts.
	function automatic collection_t shaped_collection(int unsigned ratio);
		collection_t c;
		srgt_pkg::bytes_t swap;
		logic [srgt_pkg::BYTES_W+srgt_pkg::RATIO_W-1:0] prod;
		c.drain = ($urandom_range(149, 0) == 0);
		case ($urandom_range(19, 0))
		0: begin
			c.allocated = '0;
			c.survived = rand_bytes($urandom_range(srgt_pkg::BYTES_W, 0));
		end
		1: begin
			c.allocated = rand_bytes($urandom_range(srgt_pkg::BYTES_W, 1));
			c.survived = rand_bytes(srgt_pkg::BYTES_W);
			if (c.survived < c.allocated) begin
				swap = c.survived;
				c.survived = c.allocated;
				c.allocated = swap;
			end
		end
		2: begin
			c.allocated = rand_bytes(srgt_pkg::BYTES_W);
			c.survived = rand_bytes(srgt_pkg::BYTES_W);
		end
		default: begin
			if ($urandom_range(7, 0) == 0)
				c.allocated = rand_bytes($urandom_range(16, 1));
			else
				c.allocated = rand_bytes($urandom_range(srgt_pkg::BYTES_W, 17));
			if (c.allocated == 0)
				c.allocated = srgt_pkg::bytes_t'(1);
			prod = c.allocated * ratio + 65535;
			c.survived = prod[srgt_pkg::FRAC_W +: srgt_pkg::BYTES_W];
		end
		endcase
		return c;
	endfunction

	function automatic void push_collection(srgt_pkg::bytes_t alloc, srgt_pkg::bytes_t surv,
			bit drain);
		collection_t c;
		c.allocated = alloc;
		c.survived = surv;
		c.drain = drain;
		pending_collections.push_back(c);
	endfunction

	function automatic void check_field(string name, srgt_pkg::bytes_t want,
			srgt_pkg::bytes_t got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	task automatic write_reg(logic [srgt_pkg::CFG_IDX_W-1:0] idx,
			logic [srgt_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		tune_config(idx, val);
		cfg_ch.valid <= 1'b0;
	endtask

	// Sampled away from the rising edge so that the sender's and receiver's updates have settled.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_collections.size() != 0 || collect_ch.valid ||
				expected_tunings.size() != 0);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Collection sender: bursts of random length separated by random gaps.
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	collection_t next_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collect_ch.valid <= 1'b0;
		end else begin
			if (collect_ch.valid && collect_ch.ready)
				expected_tunings.push_back(tune_step(collect_ch.allocated_bytes,
					collect_ch.survived_bytes));
			if (!collect_ch.valid || collect_ch.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					collect_ch.valid <= 1'b0;
				end else if (pending_collections.size() != 0 &&
						!(pending_collections[0].drain && expected_tunings.size() != 0)) begin
					next_item = pending_collections.pop_front();
					collect_ch.valid <= 1'b1;
					collect_ch.allocated_bytes <= next_item.allocated;
					collect_ch.survived_bytes <= next_item.survived;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(4, 0) == 0) ? 60 : $urandom_range(20, 1);
						case ($urandom_range(19, 0))
						0, 1, 2: gap_left = $urandom_range(100, 30);
						3, 4, 5, 6, 7, 8, 9: gap_left = $urandom_range(30, 1);
						default: gap_left = 0;
						endcase
					end
				end else begin
					collect_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: checks each result against the prediction, under a stall mode redrawn at random.
	stall_mode_t stall_mode = STALL_NONE;
	int unsigned stall_left = 0;
	int unsigned ready_cycles = 0;
	tuning_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_tunings.size() == 0) begin
					$error("result item arrived with no collection outstanding");
					failures++;
				end else begin
					want = expected_tunings.pop_front();
					check_field("nursery_bytes", want.nursery, result_ch.nursery_bytes);
					check_field("promote_age", srgt_pkg::bytes_t'(want.age),
						srgt_pkg::bytes_t'(result_ch.promote_age));
					check_field("nursery_changed", srgt_pkg::bytes_t'(want.nursery_changed),
						srgt_pkg::bytes_t'(result_ch.nursery_changed));
					check_field("age_changed", srgt_pkg::bytes_t'(want.age_changed),
						srgt_pkg::bytes_t'(result_ch.age_changed));
					check_field("resize_total", srgt_pkg::bytes_t'(want.resizes),
						srgt_pkg::bytes_t'(result_ch.resize_total));
					check_field("age_change_total", srgt_pkg::bytes_t'(want.age_changes),
						srgt_pkg::bytes_t'(result_ch.age_change_total));
				end
			end
			ready_cycles++;
			if (ready_cycles % 400 == 0)
				stall_mode = stall_mode_t'($urandom_range(2, 0));
			if (stall_left != 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				case (stall_mode)
				STALL_SHORT: if ($urandom_range(2, 0) == 0) stall_left = $urandom_range(4, 1);
				STALL_LONG: if ($urandom_range(7, 0) == 0) stall_left = $urandom_range(30, 10);
				default: ;
				endcase
			end
		end
	end

	initial begin
		int unsigned phase, w, groups, g, k, centre, spread, queued;
		collect_ch.valid = 1'b0;
		collect_ch.allocated_bytes = '0;
		collect_ch.survived_bytes = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		result_ch.ready = 1'b0;
		arst_n = 1'b0;
		tune_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Field extremes under the reset settings: nothing allocated, full and zero survival,
		// survival above allocation, and a ratio just under one.
		push_collection('0, '0, 1'b0);
		push_collection('0, BYTES_MAX, 1'b0);
		push_collection(BYTES_MAX, BYTES_MAX, 1'b0);
		push_collection(BYTES_MAX, '0, 1'b0);
		push_collection(srgt_pkg::bytes_t'(1), srgt_pkg::bytes_t'(1), 1'b0);
		push_collection(srgt_pkg::bytes_t'(5), BYTES_MAX, 1'b0);
		push_collection(BYTES_MAX, BYTES_MAX - 1, 1'b0);
		push_collection(srgt_pkg::bytes_t'(3), srgt_pkg::bytes_t'(1), 1'b0);
		wait_idle();

		// Single-entry window with a zero target: every item grows up to the bounds.
		write_reg(srgt_pkg::REG_WINDOW, srgt_pkg::bytes_t'(1));
		write_reg(srgt_pkg::REG_TARGET, '0);
		repeat (6) push_collection(srgt_pkg::bytes_t'(100), srgt_pkg::bytes_t'(99), 1'b0);
		wait_idle();

		// A zero window acts as one; the top target shrinks down to the bounds. The sender
		// holds the fourth item until all earlier results are back.
		write_reg(srgt_pkg::REG_WINDOW, '0);
		write_reg(srgt_pkg::REG_TARGET, srgt_pkg::bytes_t'(16'hFFFF));
		for (k = 0; k < 7; k++)
			push_collection(srgt_pkg::bytes_t'(1000), srgt_pkg::bytes_t'(k), k == 3);

		queued = 0;
		for (phase = 0; queued < RANDOM_ITEMS; phase++) begin
			wait_idle();
			case (phase)
			0: begin
				// Nursery near the top of its range, window beyond the ring depth
				write_reg(srgt_pkg::REG_MAX_NURSERY, BYTES_MAX);
				write_reg(srgt_pkg::REG_MIN_NURSERY, 36'h8_0000_0003);
				write_reg(srgt_pkg::REG_WINDOW, (rand_bytes(srgt_pkg::BYTES_W) << srgt_pkg::WIN_W) |
					srgt_pkg::bytes_t'(63));
				write_reg(srgt_pkg::REG_TARGET, srgt_pkg::bytes_t'(1000));
			end
			1: begin
				// Inverted bounds for both nursery and age
				write_reg(srgt_pkg::REG_MIN_NURSERY, 36'h8_0000_0000);
				write_reg(srgt_pkg::REG_MAX_NURSERY, 36'h4_0000_0000);
				write_reg(srgt_pkg::REG_MIN_AGE, (rand_bytes(srgt_pkg::BYTES_W) << srgt_pkg::AGE_W) |
					srgt_pkg::bytes_t'(200));
				write_reg(srgt_pkg::REG_MAX_AGE, (rand_bytes(srgt_pkg::BYTES_W) << srgt_pkg::AGE_W) |
					srgt_pkg::bytes_t'(10));
				write_reg(srgt_pkg::REG_WINDOW, srgt_pkg::bytes_t'(5));
			end
			2: begin
				// Age pinned at the top of its range
				write_reg(srgt_pkg::REG_MAX_AGE, srgt_pkg::bytes_t'(srgt_pkg::AGE_TOP));
				write_reg(srgt_pkg::REG_MIN_AGE, srgt_pkg::bytes_t'(srgt_pkg::AGE_TOP));
				write_reg(srgt_pkg::REG_MIN_NURSERY, BYTES_MAX);
				write_reg(srgt_pkg::REG_WINDOW, (rand_bytes(srgt_pkg::BYTES_W) << srgt_pkg::WIN_W) |
					srgt_pkg::bytes_t'(WINDOW_MAX));
				write_reg(srgt_pkg::REG_TARGET,
					(rand_bytes(srgt_pkg::BYTES_W) << srgt_pkg::TARGET_W) |
					srgt_pkg::bytes_t'(16'hFFFF));
			end
			3: begin
				// Age floor at zero, tiny nursery range; the spare index changes nothing
				write_reg(srgt_pkg::REG_MIN_AGE, '0);
				write_reg(srgt_pkg::REG_MAX_AGE, srgt_pkg::bytes_t'(3));
				write_reg(srgt_pkg::REG_MIN_NURSERY, srgt_pkg::bytes_t'(1));
				write_reg(srgt_pkg::REG_MAX_NURSERY, srgt_pkg::bytes_t'(1000));
				write_reg(srgt_pkg::REG_WINDOW, srgt_pkg::bytes_t'(2));
				write_reg(srgt_pkg::REG_TARGET, srgt_pkg::bytes_t'(300));
				write_reg(REG_SPARE, rand_bytes(srgt_pkg::BYTES_W));
			end
			4: begin
				write_reg(srgt_pkg::REG_WINDOW, rand_bytes(srgt_pkg::BYTES_W) << srgt_pkg::WIN_W);
				write_reg(srgt_pkg::REG_TARGET, '0);
			end
			default: begin
				if ($urandom_range(1, 0))
					write_reg(srgt_pkg::REG_MIN_NURSERY, pick_bytes());
				if ($urandom_range(1, 0))
					write_reg(srgt_pkg::REG_MAX_NURSERY, pick_bytes());
				if ($urandom_range(1, 0))
					write_reg(srgt_pkg::REG_MIN_AGE,
						(rand_bytes(srgt_pkg::BYTES_W) << srgt_pkg::AGE_W) | pick_age(6));
				if ($urandom_range(1, 0))
					write_reg(srgt_pkg::REG_MAX_AGE,
						(rand_bytes(srgt_pkg::BYTES_W) << srgt_pkg::AGE_W) | pick_age(20));
				if ($urandom_range(1, 0))
					write_reg(srgt_pkg::REG_TARGET,
						(rand_bytes(srgt_pkg::BYTES_W) << srgt_pkg::TARGET_W) |
						(($urandom_range(3, 0) == 0) ? rand_bytes(srgt_pkg::TARGET_W) :
						srgt_pkg::bytes_t'($urandom_range(20000, 2000))));
				if ($urandom_range(1, 0))
					write_reg(srgt_pkg::REG_WINDOW,
						(rand_bytes(srgt_pkg::BYTES_W) << srgt_pkg::WIN_W) | pick_window());
			end
			endcase

			// Whole windows of related ratios, sometimes followed by a partial window so that
			// the next phase starts with the ring pointer part way round.
			w = window_eff();
			groups = $urandom_range(4, 1);
			for (g = 0; g < groups; g++) begin
				centre = pick_centre();
				spread = pick_spread();
				for (k = 0; k < w; k++) begin
					pending_collections.push_back(shaped_collection(near_ratio(centre, spread)));
					queued++;
				end
			end
			if (phase == 0 || $urandom_range(2, 0) == 0) begin
				for (k = $urandom_range(w - 1, 0); k > 0; k--) begin
					pending_collections.push_back(
						shaped_collection($urandom_range(32'(srgt_pkg::Q_ONE), 0)));
					queued++;
				end
			end
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && expected_tunings.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#16ms;
		$display("FAILURE");
		$finish;
	end

endmodule

/* survival_ratio_generation_tuner.f */
rtl/srgt_pkg.sv
rtl/srgt_if.sv
rtl/survival_ratio_generation_tuner.sv
rtl/srgt_checker.sv
tb/tb_survival_ratio_generation_tuner.sv
